### rtl/scbio_pkg.sv
package scbio_pkg;

    localparam int RAM_WORDS      = 65536;
    localparam int BOOT_ROM_WORDS = 64;
    localparam int RAM_AW         = $clog2(RAM_WORDS);
    localparam int ROM_AW         = $clog2(BOOT_ROM_WORDS);

    typedef logic [RAM_AW-1:0] ram_addr_t;

    // One bus access as presented on the request side
    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        page_flag;
        logic [7:0]  dsp_read_data;
        logic [7:0]  cpu_port_read_data;
        logic [2:0]  timer_ticks;
    } req_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       dsp_write_valid;
        logic [6:0] dsp_reg_index;
        logic [1:0] port_clear_mask;
        logic [2:0] timer_enable_mask;
        logic [2:0] timer_restart_mask;
        logic [4:0] prescale_step;
        logic [1:0] timer_mode_bits;
        logic       cpu_sync_needed;
    } rsp_word_t;

    // Controller to datapath
    typedef struct packed {
        logic      capture;
        logic      execute;
        logic      clear_we;
        ram_addr_t clear_addr;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    localparam logic BUS_READ  = 1'b0;
    localparam logic BUS_WRITE = 1'b1;

    localparam logic [7:0] RAM_OFF_DATA = 8'h5A;

    localparam logic [7:0] BOOT_IMAGE [BOOT_ROM_WORDS] = '{
        8'hCD, 8'hEF, 8'hBD, 8'hE8, 8'h00, 8'hC6, 8'h1D, 8'hD0,
        8'hFC, 8'h8F, 8'hAA, 8'hF4, 8'h8F, 8'hBB, 8'hF5, 8'h78,
        8'hCC, 8'hF4, 8'hD0, 8'hFB, 8'h2F, 8'h19, 8'hEB, 8'hF4,
        8'hD0, 8'hFC, 8'h7E, 8'hF4, 8'hD0, 8'h0B, 8'hE4, 8'hF5,
        8'hCB, 8'hF4, 8'hD7, 8'h00, 8'hFC, 8'hD0, 8'hF3, 8'hAB,
        8'h01, 8'h10, 8'hEF, 8'h7E, 8'hF4, 8'h10, 8'hEB, 8'hBA,
        8'hF6, 8'hDA, 8'h00, 8'hBA, 8'hF4, 8'hC4, 8'hF4, 8'hDD,
        8'h5D, 8'hD0, 8'hDB, 8'h1F, 8'h00, 8'h00, 8'hC0, 8'hFF
    };

endpackage

### rtl/scbio_req_if.sv
interface scbio_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        page_flag;
    logic [7:0]  dsp_read_data;
    logic [7:0]  cpu_port_read_data;
    logic [2:0]  timer_ticks;

    modport source (
        output valid, operation, address, write_data, page_flag,
               dsp_read_data, cpu_port_read_data, timer_ticks,
        input  ready
    );

    modport sink (
        input  valid, operation, address, write_data, page_flag,
               dsp_read_data, cpu_port_read_data, timer_ticks,
        output ready
    );
endinterface

### rtl/scbio_rsp_if.sv
interface scbio_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       dsp_write_valid;
    logic [6:0] dsp_reg_index;
    logic [1:0] port_clear_mask;
    logic [2:0] timer_enable_mask;
    logic [2:0] timer_restart_mask;
    logic [4:0] prescale_step;
    logic [1:0] timer_mode_bits;
    logic       cpu_sync_needed;

    modport source (
        output valid, read_data, dsp_write_valid, dsp_reg_index, port_clear_mask,
               timer_enable_mask, timer_restart_mask, prescale_step, timer_mode_bits,
               cpu_sync_needed,
        input  ready
    );

    modport sink (
        input  valid, read_data, dsp_write_valid, dsp_reg_index, port_clear_mask,
               timer_enable_mask, timer_restart_mask, prescale_step, timer_mode_bits,
               cpu_sync_needed,
        output ready
    );
endinterface

### rtl/scbio_ctrl.sv
module scbio_ctrl
    import scbio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    ram_addr_t  clear_addr_reg, clear_addr_next;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        req_ready       = 1'b0;
        cmd             = '0;
        cmd.clear_addr  = clear_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we    = 1'b1;
                clear_addr_next = clear_addr_reg + 1'b1;
                if (&clear_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the new word
                if (status.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

endmodule

### rtl/scbio_datapath.sv
module scbio_datapath
    import scbio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_word_t  req_word,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    scbio_rsp_if.source rsp
);

    localparam logic [11:0] IO_PAGE  = 12'h00F;
    localparam logic [9:0]  ROM_PAGE = 10'h3FF;

    localparam logic [3:0] R_TEST  = 4'h0;
    localparam logic [3:0] R_CTRL  = 4'h1;
    localparam logic [3:0] R_DADDR = 4'h2;
    localparam logic [3:0] R_DDATA = 4'h3;
    localparam logic [3:0] R_PORT0 = 4'h4;
    localparam logic [3:0] R_PORT1 = 4'h5;
    localparam logic [3:0] R_PORT2 = 4'h6;
    localparam logic [3:0] R_PORT3 = 4'h7;
    localparam logic [3:0] R_AUX0  = 4'h8;
    localparam logic [3:0] R_AUX1  = 4'h9;
    localparam logic [3:0] R_TGT0  = 4'hA;
    localparam logic [3:0] R_TGT1  = 4'hB;
    localparam logic [3:0] R_TGT2  = 4'hC;
    localparam logic [3:0] R_CNT0  = 4'hD;
    localparam logic [3:0] R_CNT1  = 4'hE;
    localparam logic [3:0] R_CNT2  = 4'hF;

    logic [7:0] ram_mem [RAM_WORDS];
    logic [7:0] ram_rd_reg;
    req_word_t  acc_reg;

    logic            boot_rom_on_reg, boot_rom_on_next;
    logic            ram_off_reg, ram_off_next;
    logic            ram_write_ok_reg, ram_write_ok_next;
    logic [3:0]      speed_reg, speed_next;
    logic [1:0]      tflags_reg, tflags_next;
    logic [7:0]      dsp_index_reg, dsp_index_next;
    logic [1:0][7:0] scratch_reg, scratch_next;
    logic [2:0]      tenable_reg, tenable_next;
    logic [2:0][7:0] target_reg, target_next;
    logic [2:0][3:0] tcount_reg, tcount_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_word_t       rsp_reg, rsp_next;

    logic       is_io, port_wr, exec_we, ram_we;
    logic [3:0] lo;
    logic [7:0] main_rd;
    ram_addr_t  ram_waddr;
    logic [7:0] ram_wdata;

    assign is_io = (acc_reg.address[15:4] == IO_PAGE);
    assign lo    = acc_reg.address[3:0];

    // Boot ROM overlay wins over a disabled RAM
    always_comb
    begin
        if ((acc_reg.address[15:ROM_AW] == ROM_PAGE) && boot_rom_on_reg)
        begin
            main_rd = BOOT_IMAGE[acc_reg.address[ROM_AW-1:0]];
        end
        else if (ram_off_reg)
        begin
            main_rd = RAM_OFF_DATA;
        end
        else
        begin
            main_rd = ram_rd_reg;
        end
    end

    always_comb
    begin
        boot_rom_on_next  = boot_rom_on_reg;
        ram_off_next      = ram_off_reg;
        ram_write_ok_next = ram_write_ok_reg;
        speed_next        = speed_reg;
        tflags_next       = tflags_reg;
        dsp_index_next    = dsp_index_reg;
        scratch_next      = scratch_reg;
        tenable_next      = tenable_reg;
        target_next       = target_reg;
        tcount_next       = tcount_reg;
        port_wr           = 1'b0;
        rsp_next          = '0;

        // ticks land before the access itself
        for (int i = 0; i < 3; i++)
        begin
            if (acc_reg.timer_ticks[i])
            begin
                tcount_next[i] = tcount_reg[i] + 1'b1;
            end
        end

        if (acc_reg.operation == BUS_READ)
        begin
            if (is_io)
            begin
                unique case (lo) inside
                    R_DADDR: rsp_next.read_data = dsp_index_reg;
                    R_DDATA: rsp_next.read_data = acc_reg.dsp_read_data;
                    R_PORT0, R_PORT1, R_PORT2, R_PORT3:
                    begin
                        rsp_next.read_data       = acc_reg.cpu_port_read_data;
                        rsp_next.cpu_sync_needed = 1'b1;
                    end
                    R_AUX0: rsp_next.read_data = scratch_reg[0];
                    R_AUX1: rsp_next.read_data = scratch_reg[1];
                    R_CNT0:
                    begin
                        rsp_next.read_data = {4'h0, tcount_next[0]};
                        tcount_next[0]     = '0;
                    end
                    R_CNT1:
                    begin
                        rsp_next.read_data = {4'h0, tcount_next[1]};
                        tcount_next[1]     = '0;
                    end
                    R_CNT2:
                    begin
                        rsp_next.read_data = {4'h0, tcount_next[2]};
                        tcount_next[2]     = '0;
                    end
                    default: rsp_next.read_data = '0;   // write-only registers
                endcase
            end
            else
            begin
                rsp_next.read_data = main_rd;
            end
        end
        else if (is_io)
        begin
            unique case (lo) inside
                R_TEST:
                begin
                    if (!acc_reg.page_flag)
                    begin
                        speed_next        = acc_reg.write_data[7:4];
                        tflags_next       = {acc_reg.write_data[0], acc_reg.write_data[3]};
                        ram_off_next      = acc_reg.write_data[2];
                        ram_write_ok_next = acc_reg.write_data[1];
                    end
                end
                R_CTRL:
                begin
                    boot_rom_on_next         = acc_reg.write_data[7];
                    rsp_next.port_clear_mask = acc_reg.write_data[5:4];
                    rsp_next.cpu_sync_needed = |acc_reg.write_data[5:4];
                    tenable_next             = acc_reg.write_data[2:0];
                    for (int i = 0; i < 3; i++)
                    begin
                        if (!tenable_reg[i] && acc_reg.write_data[i])
                        begin
                            rsp_next.timer_restart_mask[i] = 1'b1;
                            tcount_next[i]                 = '0;
                        end
                    end
                end
                R_DADDR: dsp_index_next = acc_reg.write_data;
                R_DDATA: rsp_next.dsp_write_valid = ~dsp_index_reg[7];
                R_PORT0, R_PORT1, R_PORT2, R_PORT3:
                begin
                    port_wr                  = 1'b1;
                    rsp_next.cpu_sync_needed = 1'b1;
                end
                R_AUX0: scratch_next[0] = acc_reg.write_data;
                R_AUX1: scratch_next[1] = acc_reg.write_data;
                R_TGT0: target_next[0]  = acc_reg.write_data;
                R_TGT1: target_next[1]  = acc_reg.write_data;
                R_TGT2: target_next[2]  = acc_reg.write_data;
                default: ;                                   // read-only counters
            endcase
        end

        rsp_next.dsp_reg_index     = dsp_index_next[6:0];
        rsp_next.timer_enable_mask = tenable_next;
        rsp_next.prescale_step     = (5'd1 << speed_next[3:2]) + (5'd2 << speed_next[1:0]);
        rsp_next.timer_mode_bits   = tflags_next;
    end

    // RAM follow-through uses the freshly written test register
    assign exec_we   = cmd.execute && (acc_reg.operation == BUS_WRITE)
                       && (port_wr || (ram_write_ok_next && !ram_off_next));
    assign ram_we    = cmd.clear_we || exec_we;
    assign ram_waddr = cmd.clear_we ? cmd.clear_addr : acc_reg.address;
    assign ram_wdata = cmd.clear_we ? 8'h00 : acc_reg.write_data;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_waddr] <= ram_wdata;
        end
        if (cmd.capture)
        begin
            ram_rd_reg <= ram_mem[req_word.address];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            acc_reg <= req_word;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign status.out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.execute)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_rom_on_reg  <= 1'b1;
            ram_off_reg      <= 1'b0;
            ram_write_ok_reg <= 1'b1;
            speed_reg        <= '0;
            tflags_reg       <= 2'b01;
            dsp_index_reg    <= '0;
            scratch_reg      <= '0;
            tenable_reg      <= '0;
            target_reg       <= '0;
            tcount_reg       <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.execute)
            begin
                boot_rom_on_reg  <= boot_rom_on_next;
                ram_off_reg      <= ram_off_next;
                ram_write_ok_reg <= ram_write_ok_next;
                speed_reg        <= speed_next;
                tflags_reg       <= tflags_next;
                dsp_index_reg    <= dsp_index_next;
                scratch_reg      <= scratch_next;
                tenable_reg      <= tenable_next;
                target_reg       <= target_next;
                tcount_reg       <= tcount_next;
            end
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.read_data          = rsp_reg.read_data;
    assign rsp.dsp_write_valid    = rsp_reg.dsp_write_valid;
    assign rsp.dsp_reg_index      = rsp_reg.dsp_reg_index;
    assign rsp.port_clear_mask    = rsp_reg.port_clear_mask;
    assign rsp.timer_enable_mask  = rsp_reg.timer_enable_mask;
    assign rsp.timer_restart_mask = rsp_reg.timer_restart_mask;
    assign rsp.prescale_step      = rsp_reg.prescale_step;
    assign rsp.timer_mode_bits    = rsp_reg.timer_mode_bits;
    assign rsp.cpu_sync_needed    = rsp_reg.cpu_sync_needed;

endmodule

### rtl/sound_cpu_bus_and_io_registers.sv
// Bus and I/O register block of the sound CPU: 64 KiB work RAM, a 64-byte boot ROM
// overlaid on FFC0-FFFF and the I/O page 00F0-00FF. Each request word is one bus read
// or write; each yields exactly one response word. Accepting a request issues the
// single-port RAM read; the execute state that follows applies the register updates
// and any RAM write and loads the response register. A new request is taken
// while an earlier response still waits, but the execute state holds until the
// response register is free. After reset the work RAM is zeroed by a clearing pass,
// one byte per cycle, during which no request is accepted.
module sound_cpu_bus_and_io_registers
    import scbio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    scbio_req_if.sink   req,
    scbio_rsp_if.source rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;
    req_word_t  req_word;

    assign req_word = '{
        operation:          req.operation,
        address:            req.address,
        write_data:         req.write_data,
        page_flag:          req.page_flag,
        dsp_read_data:      req.dsp_read_data,
        cpu_port_read_data: req.cpu_port_read_data,
        timer_ticks:        req.timer_ticks
    };

    scbio_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    scbio_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_word (req_word),
        .cmd      (cmd),
        .status   (status),
        .rsp      (rsp)
    );

endmodule
